FILE: rtl/grid_cell_range_enumerator_defines.svh
// Assertion macros for the grid cell range enumerator.
// Included by the top level; no other dependencies.
`ifndef GRID_CELL_RANGE_ENUMERATOR_DEFINES_SVH
`define GRID_CELL_RANGE_ENUMERATOR_DEFINES_SVH
`ifndef SYNTH
`define GCRE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcre assertion failed");
`define GCRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcre assertion failed");
`else
`define GCRE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GCRE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/gcre_pkg.sv
// Package for the grid cell range enumerator: sizes, register indexes and
// the types passed between front end, span queue and back end. No dependencies.
`timescale 1ns / 1ps
package gcre_pkg;
   localparam int MAX_COLUMNS     = 8;
   localparam int MAX_ROWS        = 8;
   localparam int COORD_FRAC_BITS = 16;

   localparam int COORD_W   = 32;
   localparam int SIZE_W    = 31;
   localparam int COUNT_W   = 4;
   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int ROW_W     = $clog2(MAX_ROWS + 1);
   localparam int ACC_W     = COORD_W + COUNT_W + 4;
   localparam int DBL_W     = COORD_W + 2;
   localparam int MAX_DIM   = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int STEP_W    = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int REQ_W     = 4 * COORD_W;
   localparam int RSP_W     = ((COL_W + ROW_W + 7) / 8) * 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(100 << COORD_FRAC_BITS);

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT    = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [SIZE_W-1:0]  grid_width;
      logic [SIZE_W-1:0]  grid_height;
      logic [COUNT_W-1:0] column_count;
      logic [COUNT_W-1:0] row_count;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col_first;
      logic [COL_W-1:0] col_last;
      logic [ROW_W-1:0] row_first;
      logic [ROW_W-1:0] row_last;
      logic             no_cells;
   } span_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;
endpackage

FILE: rtl/gcre_front.sv
// Front end: accepts a box, scales it and counts cell boundaries below each
// limit, one boundary a cycle, then pushes the cell span. Uses gcre_pkg.
`timescale 1ns / 1ps
module gcre_front (
   input  logic                           clock,
   input  logic                           reset,
   input  gcre_pkg::cfg_type              cfg,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gcre_pkg::REQ_W-1:0]     req_tdata,
   input  gcre_pkg::queue_status_type     queue_status,
   output logic                           push,
   output gcre_pkg::span_type             span
);
   import gcre_pkg::*;

   localparam logic [1:0] F_IDLE  = 2'd0;
   localparam logic [1:0] F_PREP  = 2'd1;
   localparam logic [1:0] F_COUNT = 2'd2;
   localparam logic [1:0] F_PUSH  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic signed [COORD_W-1:0] rx0_ff, rx1_ff, ry0_ff, ry1_ff;
   logic signed [ACC_W-1:0] ax0_ff, ax1_ff, ay0_ff, ay1_ff;
   logic signed [ACC_W-1:0] ax0_in, ax1_in, ay0_in, ay1_in;
   logic signed [ACC_W-1:0] thr_x_ff, thr_y_ff, thr_x_in, thr_y_in;
   logic x_below_ff, x_above_ff, y_below_ff, y_above_ff;
   logic x_below_in, x_above_in, y_below_in, y_above_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COL_W-1:0] ix0_ff, ix1_ff, ix0_in, ix1_in;
   logic [ROW_W-1:0] iy0_ff, iy1_ff, iy0_in, iy1_in;

   logic [SIZE_W-1:0]  w_eff, h_eff;
   logic [COUNT_W-1:0] nc_eff, nr_eff;
   logic signed [ACC_W-1:0] nc_s, nr_s, w_s, h_s, ncw, nrh;
   logic signed [DBL_W-1:0] rx0_dbl, rx1_dbl, ry0_dbl, ry1_dbl, w_d, h_d;
   logic accept;

   always_comb begin
      w_eff  = (cfg.grid_width == '0) ? SIZE_W'(1) : cfg.grid_width;
      h_eff  = (cfg.grid_height == '0) ? SIZE_W'(1) : cfg.grid_height;
      if (cfg.column_count == '0) begin
         nc_eff = COUNT_W'(1);
      end else if (cfg.column_count > COUNT_W'(MAX_COLUMNS)) begin
         nc_eff = COUNT_W'(MAX_COLUMNS);
      end else begin
         nc_eff = cfg.column_count;
      end
      if (cfg.row_count == '0) begin
         nr_eff = COUNT_W'(1);
      end else if (cfg.row_count > COUNT_W'(MAX_ROWS)) begin
         nr_eff = COUNT_W'(MAX_ROWS);
      end else begin
         nr_eff = cfg.row_count;
      end
      nc_s = signed'(ACC_W'(nc_eff));
      nr_s = signed'(ACC_W'(nr_eff));
      w_s  = signed'(ACC_W'(w_eff));
      h_s  = signed'(ACC_W'(h_eff));
      w_d  = signed'(DBL_W'(w_eff));
      h_d  = signed'(DBL_W'(h_eff));
   end

   assign ncw = nc_s * w_s;
   assign nrh = nr_s * h_s;
   assign rx0_dbl = DBL_W'(rx0_ff) <<< 1;
   assign rx1_dbl = DBL_W'(rx1_ff) <<< 1;
   assign ry0_dbl = DBL_W'(ry0_ff) <<< 1;
   assign ry1_dbl = DBL_W'(ry1_ff) <<< 1;

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign push       = (state_ff == F_PUSH) && !queue_status.full;

   always_comb begin
      span.col_first = ix0_ff;
      span.col_last  = ix1_ff;
      span.row_first = iy0_ff;
      span.row_last  = iy1_ff;
      span.no_cells  = ((ix0_ff == ix1_ff) && x_below_ff) || x_above_ff ||
                       ((iy0_ff == iy1_ff) && y_below_ff) || y_above_ff ||
                       (ix0_ff > ix1_ff) || (iy0_ff > iy1_ff);
   end

   always_comb begin
      state_in   = state_ff;
      ax0_in     = ax0_ff;
      ax1_in     = ax1_ff;
      ay0_in     = ay0_ff;
      ay1_in     = ay1_ff;
      thr_x_in   = thr_x_ff;
      thr_y_in   = thr_y_ff;
      x_below_in = x_below_ff;
      x_above_in = x_above_ff;
      y_below_in = y_below_ff;
      y_above_in = y_above_ff;
      step_in    = step_ff;
      ix0_in     = ix0_ff;
      ix1_in     = ix1_ff;
      iy0_in     = iy0_ff;
      iy1_in     = iy1_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_PREP;
            end
         end
         F_PREP: begin
            // 2*n*coord + n*size, compared against 2*k*size below
            ax0_in     = ((ACC_W'(rx0_ff) * nc_s) <<< 1) + ncw;
            ax1_in     = ((ACC_W'(rx1_ff) * nc_s) <<< 1) + ncw;
            ay0_in     = ((ACC_W'(ry0_ff) * nr_s) <<< 1) + nrh;
            ay1_in     = ((ACC_W'(ry1_ff) * nr_s) <<< 1) + nrh;
            thr_x_in   = w_s <<< 1;
            thr_y_in   = h_s <<< 1;
            x_below_in = rx1_dbl < -w_d;
            x_above_in = rx0_dbl > w_d;
            y_below_in = ry1_dbl < -h_d;
            y_above_in = ry0_dbl > h_d;
            step_in    = STEP_W'(1);
            ix0_in     = '0;
            ix1_in     = '0;
            iy0_in     = ROW_W'(1);
            iy1_in     = ROW_W'(1);
            state_in   = (MAX_DIM > 1) ? F_COUNT : F_PUSH;
         end
         F_COUNT: begin
            if (COUNT_W'(step_ff) < nc_eff) begin
               if (ax0_ff >= thr_x_ff) ix0_in = ix0_ff + COL_W'(1);
               if (ax1_ff >= thr_x_ff) ix1_in = ix1_ff + COL_W'(1);
            end
            if (COUNT_W'(step_ff) < nr_eff) begin
               if (ay0_ff > thr_y_ff) iy0_in = iy0_ff + ROW_W'(1);
               if (ay1_ff > thr_y_ff) iy1_in = iy1_ff + ROW_W'(1);
            end
            thr_x_in = thr_x_ff + (w_s <<< 1);
            thr_y_in = thr_y_ff + (h_s <<< 1);
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAX_DIM - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rx0_ff <= req_tdata[COORD_W-1:0];
         rx1_ff <= req_tdata[2*COORD_W-1:COORD_W];
         ry0_ff <= req_tdata[3*COORD_W-1:2*COORD_W];
         ry1_ff <= req_tdata[4*COORD_W-1:3*COORD_W];
      end
      ax0_ff     <= ax0_in;
      ax1_ff     <= ax1_in;
      ay0_ff     <= ay0_in;
      ay1_ff     <= ay1_in;
      thr_x_ff   <= thr_x_in;
      thr_y_ff   <= thr_y_in;
      x_below_ff <= x_below_in;
      x_above_ff <= x_above_in;
      y_below_ff <= y_below_in;
      y_above_ff <= y_above_in;
      step_ff    <= step_in;
      ix0_ff     <= ix0_in;
      ix1_ff     <= ix1_in;
      iy0_ff     <= iy0_in;
      iy1_ff     <= iy1_in;
   end
endmodule

FILE: rtl/gcre_queue.sv
// Short span queue between front and back end.
// Uses gcre_pkg for the span type and depth.
`timescale 1ns / 1ps
module gcre_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gcre_pkg::span_type         push_data,
   input  logic                       pop,
   output gcre_pkg::span_type         pop_data,
   output gcre_pkg::queue_status_type status
);
   import gcre_pkg::*;

   span_type mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

FILE: rtl/gcre_back.sv
// Back end: walks a cell span, columns outer and rows inner, one cell per
// transfer into the result register. Uses gcre_pkg.
`timescale 1ns / 1ps
module gcre_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gcre_pkg::span_type         span,
   input  gcre_pkg::queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [gcre_pkg::RSP_W-1:0] rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import gcre_pkg::*;

   span_type cur_ff, cur_in;
   logic busy_ff, busy_in;
   logic [COL_W-1:0] col_ff, col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] row_ff, row_in, out_row_ff, out_row_in;
   logic valid_ff, valid_in, none_ff, none_in, last_ff, last_in;
   logic load_ok, at_end;

   assign load_ok = !valid_ff || rsp_tready;
   assign pop     = !busy_ff && !queue_status.empty;
   assign at_end  = (col_ff == cur_ff.col_last) && (row_ff == cur_ff.row_last);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_W'({out_row_ff, out_col_ff});
   assign rsp_tuser  = none_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      cur_in     = cur_ff;
      busy_in    = busy_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      valid_in   = valid_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      none_in    = none_ff;
      last_in    = last_ff;
      if (pop) begin
         cur_in  = span;
         col_in  = span.col_first;
         row_in  = span.row_first;
         busy_in = 1'b1;
      end
      if (load_ok) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            if (cur_ff.no_cells) begin
               out_col_in = '0;
               out_row_in = '0;
               none_in    = 1'b1;
               last_in    = 1'b1;
               busy_in    = 1'b0;
            end else begin
               out_col_in = col_ff;
               out_row_in = row_ff;
               none_in    = 1'b0;
               last_in    = at_end;
               if (at_end) begin
                  busy_in = 1'b0;
               end else if (row_ff == cur_ff.row_last) begin
                  row_in = cur_ff.row_first;
                  col_in = col_ff + COL_W'(1);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
      none_ff    <= none_in;
      last_ff    <= last_in;
   end
endmodule

FILE: rtl/grid_cell_range_enumerator.sv
// Grid cell range enumerator, top level: configuration registers, front end,
// span queue and back end. Uses gcre_pkg and grid_cell_range_enumerator_defines.svh.
//
// req_* takes one box per transfer: four signed Q16.16 limits. rsp_* gives one
// transfer per overlapped cell, columns outer and rows inner; rsp_tlast marks
// the final cell of a box, rsp_tuser marks the single result of a box that
// covers no cell. csr_* writes the grid size and cell counts, one register per
// cycle; the user writes them only while the block is idle, and the block
// itself does not enforce it. The front end works on one box at a time: it
// accepts the box, scales it, runs the boundary compares on its shared
// boundary counter and pushes the span, waiting while the queue is full. The
// back end gives one cell per cycle while the receiver does not stall, pausing
// between boxes to load the next span, and the front end works on the next box
// meanwhile.
// A two-entry span queue decouples the two ends: when the receiver stalls, the
// result register holds, the queue fills and then req_tready stays low.
// Reset clears the handshakes and loads the register reset values
// (100.0 by 100.0 grid, 8 columns, 8 rows).
`timescale 1ns / 1ps
`include "grid_cell_range_enumerator_defines.svh"
module grid_cell_range_enumerator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // box_min_x, box_max_x, box_min_y, box_max_y
   input  logic [gcre_pkg::REQ_W-1:0]        req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // column_index, row_index, zero pad
   output logic [gcre_pkg::RSP_W-1:0]        rsp_tdata,
   // no_cells
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [gcre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcre_pkg::SIZE_W-1:0]       csr_wdata
);
   import gcre_pkg::*;

   cfg_type cfg_ff, cfg_in;
   span_type front_span, queue_span;
   queue_status_type queue_status;
   logic push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_GRID_WIDTH:   cfg_in.grid_width   = csr_wdata;
            REG_GRID_HEIGHT:  cfg_in.grid_height  = csr_wdata;
            REG_COLUMN_COUNT: cfg_in.column_count = csr_wdata[COUNT_W-1:0];
            REG_ROW_COUNT:    cfg_in.row_count    = csr_wdata[COUNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width   <= GRID_SIZE_RESET;
         cfg_ff.grid_height  <= GRID_SIZE_RESET;
         cfg_ff.column_count <= COUNT_W'(MAX_COLUMNS);
         cfg_ff.row_count    <= COUNT_W'(MAX_ROWS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcre_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_status (queue_status),
      .push         (push),
      .span         (front_span)
   );

   gcre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_span),
      .pop       (pop),
      .pop_data  (queue_span),
      .status    (queue_status)
   );

   gcre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .span         (queue_span),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   `GCRE_ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `GCRE_ASSERT_IMPLY(a_empty_zero_idx, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `GCRE_ASSERT_IMPLY(a_row_from_one, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[COL_W+ROW_W-1:COL_W] != '0)
   `GCRE_ASSERT_NEXT(a_one_box_at_once, clock, reset, req_tvalid && req_tready, !req_tready)
   `GCRE_ASSERT_IMPLY(a_no_overflow, clock, reset, queue_status.full, !push)
endmodule
